### src/bsle_pkg.sv
// shared types and constants of the bounded sequence list engine
// no dependencies; imported by bsle_core and bounded_sequence_list_engine
`default_nettype none

package bsle_pkg;

	// default number of stored elements
	localparam int BSLE_DEPTH = 32;

	// field widths of one command and one result beat
	localparam int OPCODE_W   = 3;
	localparam int VALUE_W    = 32;
	localparam int POSITION_W = 6;
	localparam int COUNT_W    = 6;
	localparam int STATUS_W   = 2;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_DELETE    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_DUMP      = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

	// one command beat
	typedef struct packed {
		logic [OPCODE_W-1:0]          opcode;
		logic signed [VALUE_W-1:0]    value;
		logic [POSITION_W-1:0]        position;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic signed [VALUE_W-1:0]    element;
		logic [COUNT_W-1:0]           count;
		logic [STATUS_W-1:0]          status;
		logic                         last;
	} res_t;

endpackage

`default_nettype wire

### src/bsle_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module bsle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/bsle_core.sv
// sequencer of the list engine: ring pointer, count and element ram access
// depends on bsle_pkg and bsle_ram
`default_nettype none

module bsle_core #(
	parameter int DEPTH = bsle_pkg::BSLE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire bsle_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_ready,
	output bsle_pkg::res_t     res
);

	import bsle_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_DUMP  = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       front_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       k_q;
	logic [STATUS_W-1:0] status_q;

	logic                accept;
	logic                res_fire;
	logic                full;
	logic                pos_ok;
	logic [CW-1:0]       pos_idx;
	logic [AW-1:0]       front_dec;
	logic                dump_last;
	logic                shift_last;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;

	// ring slot of list index idx, idx never above DEPTH
	function automatic logic [AW-1:0] ring(input logic [AW-1:0] f, input logic [CW:0] idx);
		logic [CW+1:0] s;
		s = (CW+2)'(f) + (CW+2)'(idx);
		if (s >= (CW+2)'(DEPTH)) begin
			s = s - (CW+2)'(DEPTH);
		end
		return AW'(s);
	endfunction

	// handshake and decode
	assign cmd_ready  = (state_q == S_IDLE);
	assign accept     = cmd_valid && cmd_ready;
	assign res_valid  = (state_q == S_RESP) || (state_q == S_DUMP);
	assign res_fire   = res_valid && res_ready;
	assign full       = (cnt_q == CW'(DEPTH));
	assign pos_ok     = (cmd.position != '0) && ((CW+POSITION_W)'(cmd.position) <=
	                    (CW+POSITION_W)'(cnt_q));
	assign pos_idx    = CW'(cmd.position);
	assign front_dec  = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign dump_last  = ((CW+1)'(k_q) + (CW+1)'(1)) == (CW+1)'(cnt_q);
	assign shift_last = ((CW+1)'(k_q) + (CW+1)'(2)) == (CW+1)'(cnt_q);

	// ram address and write selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = front_dec;
		ram_wdata = cmd.value;
		ram_raddr = ring(front_q, '0);
		case (state_q)
			S_IDLE: begin
				if (cmd.opcode == OP_DELETE) begin
					ram_raddr = ring(front_q, (CW+1)'(pos_idx));
				end
				if (accept && !full && cmd.opcode == OP_INS_FRONT) begin
					ram_we    = 1'b1;
					ram_waddr = front_dec;
				end
				if (accept && !full && cmd.opcode == OP_INS_BACK) begin
					ram_we    = 1'b1;
					ram_waddr = ring(front_q, (CW+1)'(cnt_q));
				end
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = ring(front_q, (CW+1)'(k_q));
				ram_wdata = ram_rdata;
				ram_raddr = ring(front_q, (CW+1)'(k_q) + (CW+1)'(2));
			end
			S_DUMP: begin
				ram_raddr = ring(front_q, res_fire ? (CW+1)'(k_q) + (CW+1)'(1) : (CW+1)'(k_q));
			end
			default: begin
				ram_raddr = ring(front_q, '0);
			end
		endcase
	end

	bsle_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			cnt_q    <= '0;
			k_q      <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.opcode)
							OP_INS_FRONT: begin
								state_q <= S_RESP;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									front_q  <= front_dec;
									cnt_q    <= cnt_q + 1'b1;
								end
							end
							OP_INS_BACK: begin
								state_q <= S_RESP;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									cnt_q    <= cnt_q + 1'b1;
								end
							end
							OP_DELETE: begin
								if (!pos_ok) begin
									status_q <= ST_BAD_POS;
									state_q  <= S_RESP;
								end else if (pos_idx == cnt_q) begin
									status_q <= ST_OK;
									cnt_q    <= cnt_q - 1'b1;
									state_q  <= S_RESP;
								end else begin
									k_q     <= pos_idx - 1'b1;
									state_q <= S_SHIFT;
								end
							end
							OP_DUMP: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									k_q     <= '0;
									state_q <= S_DUMP;
								end
							end
							OP_CLEAR: begin
								cnt_q    <= '0;
								front_q  <= '0;
								status_q <= ST_OK;
								state_q  <= S_RESP;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// one entry moves down per cycle
					if (shift_last) begin
						cnt_q    <= cnt_q - 1'b1;
						status_q <= ST_OK;
						state_q  <= S_RESP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DUMP: begin
					if (res_fire) begin
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_RESP: begin
					if (res_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat
	always_comb begin
		res.element = (state_q == S_DUMP) ? $signed(ram_rdata) : '0;
		res.count   = COUNT_W'(cnt_q);
		res.status  = (state_q == S_DUMP) ? ST_OK : status_q;
		res.last    = (state_q == S_DUMP) ? dump_last : 1'b1;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(front_q) < (CW+1)'(DEPTH))
		else $error("front index outside the ring");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> ((CW+1)'(k_q) + (CW+1)'(2)) <= (CW+1)'(cnt_q))
		else $error("shift moves an entry outside the live range");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (cnt_q != '0) && !ram_we)
		else $error("dump on empty list or with a ram write");

	a_dump_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) && !res_ready |=> (state_q == S_DUMP) && $stable(k_q))
		else $error("dump index moved while stalled");
`endif

endmodule

`default_nettype wire

### src/bounded_sequence_list_engine.sv
// top level of the bounded sequence list engine: stream ports and output register
// depends on bsle_pkg and bsle_core
`default_nettype none

// Usage
// Command beats enter on the s_ channel: s_tuser carries the opcode, s_tdata the
// value to insert and the 1-based delete position. Result beats leave on the m_
// channel: m_tdata carries the element and the new count, m_tuser the status and
// m_tlast marks the final beat of a command.
// Insert, clear and a refused command give one beat, registered in the response
// state and then in the output register. Delete at position p of n entries walks
// the element ram one entry per cycle, moving the n - p entries behind it, before
// its beat. Dump gives one beat per cycle while m_tready is high, the first from
// the dump state through the output register. Unknown opcodes give no beat.
// The sequencer takes one command at a time, busy through a delete or dump walk.
// A finished beat waits in the output register, so the next command is taken
// while it is pending. Stalling m_tready holds the beat and pauses a dump.
// Reset empties the list at once (count and front index cleared); the element ram
// is not cleared and needs no sweep.

module bounded_sequence_list_engine #(
	parameter int DEPTH = bsle_pkg::BSLE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // value [31:0], position [37:32], zero pad
	input  wire logic [2:0]  s_tuser,   // opcode [2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // element [31:0], count [37:32], zero pad
	output logic [1:0]       m_tuser,   // status [1:0]
	output logic             m_tlast
);

	import bsle_pkg::*;

	cmd_t cmd;
	res_t core_res;
	logic core_res_valid;
	logic core_res_ready;
	logic out_vld_q;
	res_t out_q;

	// unpack the command beat
	assign cmd.opcode   = s_tuser;
	assign cmd.value    = $signed(s_tdata[31:0]);
	assign cmd.position = s_tdata[37:32];

	bsle_core #(
		.DEPTH (DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.res_valid (core_res_valid),
		.res_ready (core_res_ready),
		.res       (core_res)
	);

	// output register
	assign core_res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (core_res_ready) begin
			out_vld_q <= core_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_ready && core_res_valid) begin
			out_q <= core_res;
		end
	end

	// pack the result beat
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_q.count, out_q.element};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for bounded_sequence_list_engine
// depends on bsle_pkg and the engine rtl; keeps its own list model and
// checks every result beat against it
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsle_pkg::*;

	localparam int DEPTH       = BSLE_DEPTH;
	localparam int ITEM_TARGET = 310;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = DEPTH + 16;

	// opcodes the engine ignores
	localparam logic [OPCODE_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // value [31:0], position [37:32], zero pad
	logic [2:0]  s_tuser;   // opcode [2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // element [31:0], count [37:32], zero pad
	logic [1:0]  m_tuser;   // status [1:0]
	logic        m_tlast;

	bounded_sequence_list_engine #(.DEPTH(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// list model: ring of elements, head slot and length
	logic [VALUE_W-1:0] list_mem [DEPTH];
	int                 list_head;
	int                 list_len;
	res_t               expected_beats [$];

	// run statistics and error tally
	int fail_count;
	int items_sent;
	int beats_checked;
	int full_refusals;
	int bad_positions;
	int empty_dumps;
	int dump_commands;
	int ignored_cmds;

	// sender burst shaping and receiver hold-off request
	int burst_left;
	bit hold_off_req;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void push_beat(logic [VALUE_W-1:0] elem, logic [STATUS_W-1:0] st,
			logic lst);
		res_t b;
		b.element = elem;
		b.count   = list_len[COUNT_W-1:0];
		b.status  = st;
		b.last    = lst;
		expected_beats.push_back(b);
	endfunction

	// apply one accepted command to the list model and queue its result beats
	function automatic void list_apply(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val,
			logic [POSITION_W-1:0] pos);
		int k;
		case (op)
			OP_INS_FRONT, OP_INS_BACK: begin
				if (list_len >= DEPTH) begin
					full_refusals++;
					push_beat('0, ST_FULL, 1'b1);
				end else begin
					if (op == OP_INS_FRONT) begin
						list_head = (list_head + DEPTH - 1) % DEPTH;
						list_mem[list_head] = val;
					end else begin
						list_mem[(list_head + list_len) % DEPTH] = val;
					end
					list_len++;
					push_beat('0, ST_OK, 1'b1);
				end
			end
			OP_DELETE: begin
				if (pos < 1 || pos > list_len) begin
					bad_positions++;
					push_beat('0, ST_BAD_POS, 1'b1);
				end else begin
					for (k = pos - 1; k + 1 < list_len; k++)
						list_mem[(list_head + k) % DEPTH] =
							list_mem[(list_head + k + 1) % DEPTH];
					list_len--;
					push_beat('0, ST_OK, 1'b1);
				end
			end
			OP_DUMP: begin
				dump_commands++;
				if (list_len == 0) begin
					empty_dumps++;
					push_beat('0, ST_EMPTY, 1'b1);
				end else begin
					for (k = 0; k < list_len; k++)
						push_beat(list_mem[(list_head + k) % DEPTH], ST_OK,
							k + 1 == list_len);
				end
			end
			OP_CLEAR: begin
				list_len  = 0;
				list_head = 0;
				push_beat('0, ST_OK, 1'b1);
			end
			default: ignored_cmds++;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic note_error(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// drive one command beat; bursts with random gaps between them
	task automatic send_cmd(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val,
			logic [POSITION_W-1:0] pos);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, pos, val};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		list_apply(op, val, pos);
		if (op <= OP_CLEAR)
			items_sent++;
	endtask

	// stop offering and wait until every expected beat has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// delete position: mostly valid, sometimes zero or past the end
	function automatic logic [POSITION_W-1:0] pick_position();
		if (list_len > 0 && $urandom_range(0, 4) != 0)
			return POSITION_W'($urandom_range(1, list_len));
		if ($urandom_range(0, 2) == 0 || list_len >= 63)
			return '0;
		return POSITION_W'($urandom_range(list_len + 1, 63));
	endfunction

	// edges of every field, every opcode and the empty, bad-position and ignored cases
	task automatic test_directed_edges();
		send_cmd(OP_DUMP, '0, '0);
		send_cmd(OP_DELETE, '0, 6'd1);
		send_cmd(OP_DELETE, '0, 6'd0);
		send_cmd(OP_INS_FRONT, 32'h7fff_ffff, '0);
		send_cmd(OP_INS_BACK, 32'h8000_0000, 6'd63);
		send_cmd(OP_INS_FRONT, 32'hffff_ffff, '0);
		send_cmd(OP_INS_BACK, 32'h0000_0000, '0);
		send_cmd(OP_DUMP, '0, '0);
		send_cmd(OP_DELETE, '0, 6'd5);
		send_cmd(OP_DELETE, '0, 6'd63);
		send_cmd(OP_DELETE, '0, 6'd4);
		send_cmd(OP_DELETE, '0, 6'd1);
		send_cmd(OP_DUMP, '0, '0);
		send_cmd(OP_RSVD_5, 32'h1234_5678, 6'd1);
		send_cmd(OP_RSVD_6, '0, '0);
		send_cmd(OP_RSVD_7, 32'hffff_ffff, 6'd63);
		send_cmd(OP_CLEAR, '0, '0);
		send_cmd(OP_DUMP, '0, '0);
		send_cmd(OP_INS_BACK, 32'h5a5a_a5a5, '0);
		send_cmd(OP_DELETE, '0, 6'd1);
		send_cmd(OP_DUMP, '0, '0);
		wait_drained();
	endtask

	// fill to capacity, try to overflow, dump and trim at both ends
	task automatic test_fill_and_overflow();
		int n;
		send_cmd(OP_CLEAR, '0, '0);
		while (list_len < DEPTH)
			send_cmd($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, pick_value(), '0);
		send_cmd(OP_INS_FRONT, pick_value(), '0);
		send_cmd(OP_INS_BACK, pick_value(), '0);
		send_cmd(OP_DELETE, '0, 6'd33);
		send_cmd(OP_DUMP, '0, '0);
		send_cmd(OP_DELETE, '0, POSITION_W'(DEPTH));
		send_cmd(OP_DELETE, '0, 6'd1);
		for (n = 0; n < 4; n++)
			send_cmd(OP_DELETE, '0, POSITION_W'($urandom_range(1, list_len)));
		send_cmd(OP_DUMP, '0, '0);
	endtask

	// long receiver hold-off while commands keep coming, then a full drain
	task automatic test_output_holdoff();
		int n;
		hold_off_req = 1'b1;
		for (n = 0; n < 12; n++)
			send_cmd(OP_INS_BACK, pick_value(), '0);
		send_cmd(OP_DUMP, '0, '0);
		for (n = 0; n < 6; n++)
			send_cmd(OP_DELETE, '0, pick_position());
		send_cmd(OP_DUMP, '0, '0);
		wait_drained();
	endtask

	// random command mix with mostly valid positions
	task automatic test_random_mix(int target);
		int r;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 24)
				send_cmd(OP_INS_FRONT, pick_value(), POSITION_W'($urandom_range(0, 63)));
			else if (r < 50)
				send_cmd(OP_INS_BACK, pick_value(), POSITION_W'($urandom_range(0, 63)));
			else if (r < 74)
				send_cmd(OP_DELETE, $urandom, pick_position());
			else if (r < 88)
				send_cmd(OP_DUMP, $urandom, POSITION_W'($urandom_range(0, 63)));
			else if (r < 92)
				send_cmd(OP_CLEAR, $urandom, POSITION_W'($urandom_range(0, 63)));
			else if (r < 95)
				send_cmd(3'($urandom_range(OP_RSVD_5, OP_RSVD_7)), $urandom,
					POSITION_W'($urandom_range(0, 63)));
			else
				send_cmd(OP_INS_BACK, pick_value(), '0);
		end
	endtask

	// receiver: changing ready patterns, plus the long hold-off on request
	initial begin : recv_pattern
		int mode;
		int phase;
		m_tready = 1'b0;
		mode = 0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			if (phase % 50 == 0)
				mode = $urandom_range(0, 3);
			phase++;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (phase % 3 != 0);
			endcase
		end
	end

	// result checker: every beat against the oldest expectation
	always @(posedge clk) begin : check_beats
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_checked++;
			if (expected_beats.size() == 0) begin
				note_error($sformatf("unexpected beat elem=%h count=%0d status=%0d last=%b",
					m_tdata[31:0], m_tdata[37:32], m_tuser, m_tlast));
			end else begin
				want = expected_beats.pop_front();
				if (m_tdata[31:0] !== want.element || m_tdata[37:32] !== want.count ||
						m_tuser !== want.status || m_tlast !== want.last)
					note_error($sformatf(
						"beat %0d: exp elem=%h count=%0d status=%0d last=%b, got elem=%h count=%0d status=%0d last=%b",
						beats_checked, want.element, want.count, want.status, want.last,
						m_tdata[31:0], m_tdata[37:32], m_tuser, m_tlast));
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin : watchdog
		int idle;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle = 0;
		end else begin
			idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d beats still expected",
					IDLE_LIMIT, expected_beats.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		arst_n       = 1'b0;
		list_head    = 0;
		list_len     = 0;
		burst_left   = 0;
		hold_off_req = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_fill_and_overflow();
		test_output_holdoff();
		test_fill_and_overflow();
		test_random_mix(ITEM_TARGET);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0)
			note_error($sformatf("%0d expected beats never arrived", expected_beats.size()));

		$display("covered %0d commands (%0d ignored), %0d result beats, %0d dumps (%0d empty)",
			items_sent, ignored_cmds, beats_checked, dump_commands, empty_dumps);
		$display("refused inserts on a full list: %0d, rejected delete positions: %0d",
			full_refusals, bad_positions);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
